FILE: rtl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
package wbps_pkg;

	// Sizing
	localparam int MAX_PATTERN   = 16;
	localparam int POSITION_BITS = 32;
	localparam int PAT_REG_BYTES = 16;
	localparam int MAX_LEN       = (MAX_PATTERN < PAT_REG_BYTES) ? MAX_PATTERN : PAT_REG_BYTES;
	localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
	localparam int WIN_IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int LEN_REG_W     = 5;
	localparam int CARE_W        = 16;
	localparam int OFFSET_W      = 32;
	localparam int POS_OUT_W     = 32;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_OFFSET = 3'd4;

	// Input beat: one byte of the scanned region
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	// Output beat: one scan result
	typedef struct packed {
		logic                 found;
		logic [POS_OUT_W-1:0] match_position;
	} out_beat_t;

endpackage

FILE: rtl/wildcard_byte_pattern_scan_top.sv
// Wildcard byte pattern scanner: input register, masked window compare, result register.
//
// Bytes of a region stream in one per beat and the block takes a new byte every cycle
// while the output register is free. A byte lands in an input register; when it advances,
// the sliding window is shifted, the masked compare of the newest pattern_length bytes
// runs and any result is written to the output register. Each region gives exactly one
// result: found with start index plus match_offset on the first match, or not-found on
// the last byte. Bytes after a match are dropped until the last byte re-arms the scan.
// The input stalls only while the output register holds a result that has not been
// taken. Configuration writes are taken at once (cfg_ready is always high) and must be
// made while the block is idle.
module wildcard_byte_pattern_scan_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  wbps_pkg::in_beat_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output wbps_pkg::out_beat_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wbps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wbps_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import wbps_pkg::*;

	// Configuration registers
	logic [63:0]           pat_low_q;
	logic [63:0]           pat_high_q;
	logic [CARE_W-1:0]     care_q;
	logic [LEN_REG_W-1:0]  len_reg_q;
	logic [OFFSET_W-1:0]   offset_q;

	// Input stage
	logic     valid_s1;
	in_beat_t data_s1;

	// Scan state
	logic [7:0]               win_q [MAX_PATTERN];
	logic [LEN_W-1:0]         cnt_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic                     done_q;

	// Result register
	logic      out_valid_q;
	out_beat_t out_data_q;

	// Datapath
	logic                     advance;
	logic [7:0]               win_next [MAX_PATTERN];
	logic [LEN_W-1:0]         cnt_next;
	logic [POSITION_BITS-1:0] pos_next;
	logic [LEN_W-1:0]         len_eff;
	logic [2*64-1:0]          pat_all;
	logic [MAX_LEN-1:0]       byte_ok;
	logic [LEN_W-1:0]         idx_wide [MAX_LEN];
	logic                     hit;
	logic [POSITION_BITS-1:0] start_pos;
	logic [POSITION_BITS-1:0] match_pos;
	logic                     res_valid;
	out_beat_t                res_data;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			care_q     <= '1;
			len_reg_q  <= LEN_REG_W'(1);
			offset_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:  pat_low_q  <= cfg_data[63:0];
				REG_PATTERN_HIGH: pat_high_q <= cfg_data[63:0];
				REG_CARE_MASK:    care_q     <= cfg_data[CARE_W-1:0];
				REG_PATTERN_LEN:  len_reg_q  <= cfg_data[LEN_REG_W-1:0];
				REG_MATCH_OFFSET: offset_q   <= cfg_data[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the input stage whenever the result register can take a beat
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	// Clamp the pattern length to what the window and registers hold
	always_comb begin
		if (len_reg_q > LEN_REG_W'(MAX_LEN)) begin
			len_eff = LEN_W'(MAX_LEN);
		end else begin
			len_eff = LEN_W'(len_reg_q);
		end
	end

	// Shift the new byte into the window, advance the counters
	always_comb begin
		for (int i = 0; i < MAX_PATTERN - 1; i++) begin
			win_next[i] = win_q[i + 1];
		end
		win_next[MAX_PATTERN-1] = data_s1.data_byte;
		cnt_next = (cnt_q == LEN_W'(MAX_LEN)) ? cnt_q : cnt_q + LEN_W'(1);
		pos_next = pos_q + POSITION_BITS'(1);
	end

	// Masked compare of the newest len_eff bytes against the pattern
	assign pat_all = {pat_high_q, pat_low_q};

	always_comb begin
		for (int j = 0; j < MAX_LEN; j++) begin
			idx_wide[j] = LEN_W'(MAX_PATTERN) - len_eff + LEN_W'(j);
			byte_ok[j]  = (LEN_W'(j) >= len_eff) || !care_q[j] ||
				(win_next[idx_wide[j][WIN_IDX_W-1:0]] == pat_all[8*j +: 8]);
		end
		hit = !done_q && (len_eff != '0) && (cnt_next >= len_eff) && (&byte_ok);
	end

	// Form the result: match start plus signed offset, wrapped
	always_comb begin
		start_pos = pos_next - POSITION_BITS'(len_eff);
		match_pos = start_pos + POSITION_BITS'($signed(offset_q));
		res_valid = !done_q && (hit || data_s1.last_byte);
		res_data.found          = hit;
		res_data.match_position = hit ? POS_OUT_W'(match_pos) : '0;
	end

	// Update scan state; the last byte re-arms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pos_q  <= '0;
			done_q <= 1'b0;
		end else if (advance) begin
			if (data_s1.last_byte) begin
				cnt_q  <= '0;
				pos_q  <= '0;
				done_q <= 1'b0;
			end else if (!done_q) begin
				cnt_q <= cnt_next;
				pos_q <= pos_next;
				if (hit) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// Window contents are read only once enough bytes have arrived
	always_ff @(posedge clk) begin
		if (advance && !done_q) begin
			win_q <= win_next;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_data_q <= res_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: rtl/wbps_checker.sv
// Port-level checks for the wildcard byte pattern scanner, bound to the top level.
module wbps_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input wbps_pkg::out_beat_t             out_data,
	input logic                            cfg_valid,
	input logic                            cfg_ready
);
	import wbps_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// A not-found result carries a zero position
	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.found |-> out_data.match_position == '0)
		else $error("not-found result with nonzero position");

	// Input backpressure only comes from a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	// Configuration writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration beat refused");

	// A result needs a byte taken in before it
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready || in_valid, 2) || $past(!in_ready, 1))
		else $error("result without an input byte");

endmodule

bind wildcard_byte_pattern_scan_top wbps_checker u_wbps_checker (.*);
